// ----- src/spm_pkg.sv -----
// spm_pkg: shared constants and types for the stream pattern matcher.
// Used by spm_cfg, spm_compare and stream_pattern_match_top; no dependencies.

package spm_pkg;

  // Default sizes handed to the top-level parameters
  localparam int MAX_PATTERN_DEF   = 32;
  localparam int POSITION_BITS_DEF = 32;

  // Fixed field widths
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 6;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int START_W   = 32;

  // Pattern storage: four 64-bit words, 32 bytes
  localparam int PAT_WORDS = 4;
  localparam int PAT_BYTES = PAT_WORDS * (CFG_W / BYTE_W);
  localparam int PAT_IDX_W = $clog2(PAT_BYTES);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_0_7    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_8_15   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_16_23  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_24_31  = 3'd4;

  // Pattern-length control handed from the config block to the compare
  typedef struct packed {
    logic [LEN_W-1:0] len;     // pattern length in use
    logic             len_ok;  // length in 1..MAX_PATTERN
  } cfg_ctl_t;

endpackage

// ----- src/spm_cfg.sv -----
// spm_cfg: configuration registers and the length-aligned pattern image.
// Depends on spm_pkg.

module spm_cfg import spm_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_en,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [CFG_W-1:0]                      cfg_data,
  output cfg_ctl_t                              ctl,
  output logic [MAX_PATTERN-1:0][BYTE_W-1:0]    aligned,
  output logic [MAX_PATTERN-1:0]                mask
);

  logic [LEN_W-1:0]                   pattern_length;
  logic [PAT_WORDS-1:0][CFG_W-1:0]    pattern_words;
  logic [PAT_BYTES-1:0][BYTE_W-1:0]   pat_bytes;
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] aligned_next;
  logic [MAX_PATTERN-1:0]             mask_next;

  assign pat_bytes = pattern_words;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LEN_W'(1);
      pattern_words  <= '0;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length   <= cfg_data[LEN_W-1:0];
        REG_PATTERN_0_7:    pattern_words[0] <= cfg_data;
        REG_PATTERN_8_15:   pattern_words[1] <= cfg_data;
        REG_PATTERN_16_23:  pattern_words[2] <= cfg_data;
        REG_PATTERN_24_31:  pattern_words[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Window entry j (newest first) must equal pattern byte len-1-j
  always_comb begin
    logic [LEN_W-1:0] k;
    k            = '0;
    aligned_next = '0;
    mask_next    = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      k = pattern_length - LEN_W'(1) - LEN_W'(j);
      if (LEN_W'(j) < pattern_length) begin
        aligned_next[j] = pat_bytes[k[PAT_IDX_W-1:0]];
        mask_next[j]    = 1'b1;
      end
    end
  end

  // Register the aligned image; it follows a config write in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      aligned <= '0;
      mask    <= MAX_PATTERN'(1);
    end else begin
      aligned <= aligned_next;
      mask    <= mask_next;
    end
  end

  assign ctl.len    = pattern_length;
  assign ctl.len_ok = (pattern_length != '0) && (pattern_length <= LEN_W'(MAX_PATTERN));

endmodule

// ----- src/spm_compare.sv -----
// spm_compare: parallel byte compare of the window against the aligned pattern,
// plus start-index computation, clamped if wider than START_W. Depends on spm_pkg.

module spm_compare import spm_pkg::*; #(
  parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic [MAX_PATTERN-1:0][BYTE_W-1:0] window,
  input  logic [MAX_PATTERN-1:0][BYTE_W-1:0] aligned,
  input  logic [MAX_PATTERN-1:0]             mask,
  input  cfg_ctl_t                           ctl,
  input  logic [POSITION_BITS-1:0]           position,
  output logic                               hit,
  output logic [START_W-1:0]                 start
);

  logic [MAX_PATTERN-1:0]   byte_ok;
  logic [POSITION_BITS-1:0] len_ext;
  logic [POSITION_BITS-1:0] start_full;

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      byte_ok[j] = !mask[j] || (window[j] == aligned[j]);
    end
  end

  assign len_ext    = POSITION_BITS'(ctl.len);
  assign start_full = position - len_ext;
  assign hit        = ctl.len_ok && (position >= len_ext) && (&byte_ok);

  generate
    if (POSITION_BITS > START_W) begin : g_clamp
      assign start = (|start_full[POSITION_BITS-1:START_W]) ? '1
                                                            : start_full[START_W-1:0];
    end else begin : g_extend
      assign start = START_W'(start_full);
    end
  endgenerate

endmodule

// ----- src/stream_pattern_match_top.sv -----
// stream_pattern_match_top: exact pattern search over a byte stream.
// Depends on spm_pkg, spm_cfg and spm_compare.
//
//   channel   handshake           payload
//   -------   ---------           -------
//   input     in_valid/in_stall   text_byte[7:0], new_text
//   output    out_valid/out_stall match_start[31:0]
//   config    cfg_en (no wait)    cfg_index[2:0], cfg_data[63:0]
//
// One item per cycle sustained while no match waits on a stalled result. An
// accepted item shifts into the window register and bumps the position count
// at the accept edge; while it sits in the compare stage, MAX_PATTERN byte
// compares run in parallel and a hit loads the result register once it is free.
// match_start is driven from that result register.
// Reset (rst, synchronous) clears window, position, valids, pattern; length goes to 1.
// A non-matching item never waits on out_stall; a matching item holds the
// compare stage only while the result register is full and stalled.

module stream_pattern_match_top import spm_pkg::*; #(
  parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // text input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    text_byte,
  input  logic                 new_text,
  // match output
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [START_W-1:0]   match_start
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  cfg_ctl_t                           ctl;
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] aligned;
  logic [MAX_PATTERN-1:0]             mask;

  // Window state: newest byte in entry 0
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] window;
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_next;
  logic [POSITION_BITS-1:0]           position;
  logic [POSITION_BITS-1:0]           position_base;
  logic [POSITION_BITS-1:0]           position_next;
  logic                               cmp_valid;   // an item waits in the compare stage

  logic                               hit;
  logic [START_W-1:0]                 start;
  logic                               in_accept;
  logic                               out_free;
  logic                               cmp_move;

  spm_cfg #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .aligned   (aligned),
    .mask      (mask)
  );

  spm_compare #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_compare (
    .window   (window),
    .aligned  (aligned),
    .mask     (mask),
    .ctl      (ctl),
    .position (position),
    .hit      (hit),
    .start    (start)
  );

  // Handshake: result register frees when empty or being taken this cycle.
  assign out_free  = !out_valid || !out_stall;
  // Drop a miss at once; advance a hit only into a free result register.
  assign cmp_move  = cmp_valid && (!hit || out_free);
  assign in_stall  = cmp_valid && !cmp_move;
  assign in_accept = in_valid && !in_stall;

  // Restart clears the window and count before the new byte shifts in.
  always_comb begin
    if (new_text) begin
      window_next   = '0;
      position_base = '0;
    end else begin
      window_next   = window << BYTE_W;
      position_base = position;
    end
    window_next[0] = text_byte;
    // Saturate the count at its maximum
    position_next = (position_base == POS_MAX) ? position_base
                                               : position_base + POSITION_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= '0;
      position  <= '0;
      cmp_valid <= 1'b0;
    end else if (in_accept) begin
      window    <= window_next;
      position  <= position_next;
      cmp_valid <= 1'b1;
    end else if (cmp_move) begin
      cmp_valid <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmp_move && hit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_move && hit) begin
      match_start <= start;
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// testbench: self-checking bench for stream_pattern_match_top.
// Depends on spm_pkg and the matcher RTL; drives text bytes, predicts
// match starts and checks every result in order.

module testbench;
  import spm_pkg::*;

  localparam logic [31:0] POS_SAT      = 32'hFFFF_FFFF;
  localparam int          DRAIN_CYCLES = 4;     // result register drain plus margin
  localparam int          TEXT_TARGET  = 2000;  // random text bytes to send
  localparam int          HOLD_CYCLES  = 300;   // long receiver hold-off

  typedef struct packed {
    logic [BYTE_W-1:0] chr;
    logic              restart;
  } text_item_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
  typedef enum {PH_NORMAL, PH_LONGEST, PH_BAD_LEN} phase_kind_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    text_byte = '0;
  logic                 new_text = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [START_W-1:0]   match_start;

  stream_pattern_match_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_en(cfg_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .text_byte(text_byte),
    .new_text(new_text),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .match_start(match_start)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Matcher state mirrored in the bench: sliding window (newest byte in entry 0),
  // byte count of the current text, and the programmed pattern.
  logic [BYTE_W-1:0] win_bytes [MAX_PATTERN_DEF];
  logic [31:0]       text_pos;
  logic [LEN_W-1:0]  pat_len;
  logic [CFG_W-1:0]  pat_word [PAT_WORDS];

  text_item_t         text_queue [$];   // bytes waiting for the driver
  logic [START_W-1:0] start_queue [$];  // match starts still to come out

  int items_queued = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int holds_done   = 0;
  int input_stalls = 0;
  int phases       = 0;
  int longest_runs = 0;
  int bad_len_runs = 0;

  // Shift one byte into the mirrored window and return whether the last
  // pat_len bytes spell the pattern; start gets the occurrence's first index.
  function automatic bit match_step(input text_item_t it, output logic [START_W-1:0] start);
    int len;
    bit hit;
    if (it.restart) begin
      foreach (win_bytes[i]) win_bytes[i] = '0;
      text_pos = '0;
    end
    for (int i = MAX_PATTERN_DEF - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
    win_bytes[0] = it.chr;
    if (text_pos != POS_SAT) text_pos++;
    len = int'(pat_len);
    // zero or oversize lengths never match; neither does a too-short text
    hit = len >= 1 && len <= MAX_PATTERN_DEF && text_pos >= 32'(len);
    if (hit)
      for (int i = 0; i < len; i++)
        if (win_bytes[len-1-i] != pat_word[i/8][(i%8)*8 +: 8]) hit = 1'b0;
    start = text_pos - 32'(len);
    return hit;
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present queued bytes in bursts of random length, with random gaps
  // between bursts. A payload is held while stalled; predict on acceptance.
  // ---------------------------------------------------------------------------
  int                 burst_left = 1;
  int                 gap_left   = 0;
  text_item_t         next_item;
  logic [START_W-1:0] pred_start;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_stall) input_stalls++;
      if (in_valid && !in_stall) begin
        items_sent++;
        if (match_step({text_byte, new_text}, pred_start)) start_queue.push_back(pred_start);
      end
      // advance only when nothing is offered or the offer was just taken
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (text_queue.size() != 0) begin
          next_item = text_queue.pop_front();
          in_valid  <= 1'b1;
          text_byte <= next_item.chr;
          new_text  <= next_item.restart;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            // a quarter of bursts run straight into the next one
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted match start against the oldest prediction and
  // drive out_stall from a stall mode that is picked anew at random. Twice in
  // the run, hold off for a long stretch so the block backs up into in_stall.
  // ---------------------------------------------------------------------------
  stall_mode_t        stall_mode = STALL_NONE;
  int                 mode_left  = 0;
  int                 hold_left  = 0;
  int                 cyc        = 0;
  logic [START_W-1:0] want_start;

  always @(posedge clk) begin
    cyc++;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (start_queue.size() == 0) begin
          note_mismatch($sformatf("match_start %0d with no match pending", match_start));
        end else begin
          want_start = start_queue.pop_front();
          if (match_start !== want_start)
            note_mismatch($sformatf("match_start expected %0d got %0d", want_start, match_start));
        end
        if (results_seen == 40 || results_seen == 250) begin
          hold_left = HOLD_CYCLES;
          holds_done++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_t'($urandom_range(0, 3));
          mode_left  = $urandom_range(20, 120);
        end
        mode_left--;
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= (cyc % 3 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and configuration
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic nt);
    text_queue.push_back({b, nt});
    items_queued++;
  endtask

  // One register write per edge; keep the mirror in step with the block.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_PATTERN_LENGTH: pat_len     = data[LEN_W-1:0];
      REG_PATTERN_0_7:    pat_word[0] = data;
      REG_PATTERN_8_15:   pat_word[1] = data;
      REG_PATTERN_16_23:  pat_word[2] = data;
      REG_PATTERN_24_31:  pat_word[3] = data;
      default: ;  // unused index, the block drops it
    endcase
  endtask

  task automatic cfg_close();
    @(posedge clk);
    cfg_en <= 1'b0;
  endtask

  // Hold the sender until every byte is in and every match is out, then let
  // the pipeline empty of non-matching bytes.
  task automatic wait_idle();
    do @(negedge clk); while (text_queue.size() != 0 || in_valid || start_queue.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Program a random pattern over a small alphabet, then send text built from
  // planted copies (some broken), alphabet bytes and full-range noise.
  task automatic random_phase(input phase_kind_t kind);
    logic [BYTE_W-1:0] alpha [4];
    logic [CFG_W-1:0]  w [PAT_WORDS];
    logic [CFG_W-1:0]  d;
    int alpha_n;
    int len;
    int plant;
    int n;
    int k;
    int r;
    int bad;
    alpha_n = $urandom_range(1, 4);
    foreach (alpha[i]) alpha[i] = $urandom_range(0, 255);
    case (kind)
      PH_LONGEST: len = MAX_PATTERN_DEF;
      PH_BAD_LEN: len = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_PATTERN_DEF + 1, 63);
      default:    len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 31) : $urandom_range(1, 6);
    endcase
    foreach (w[j]) w[j] = {$urandom, $urandom};
    for (int i = 0; i < MAX_PATTERN_DEF && i < len; i++)
      w[i/8][(i%8)*8 +: 8] = alpha[$urandom_range(0, alpha_n - 1)];
    d = {$urandom, $urandom};
    d[LEN_W-1:0] = len[LEN_W-1:0];
    cfg_write(REG_PATTERN_LENGTH, d);
    cfg_write(REG_PATTERN_0_7, w[0]);
    cfg_write(REG_PATTERN_8_15, w[1]);
    cfg_write(REG_PATTERN_16_23, w[2]);
    cfg_write(REG_PATTERN_24_31, w[3]);
    if ($urandom_range(0, 3) == 0)
      cfg_write(CFG_IDX_W'($urandom_range(int'(REG_PATTERN_24_31) + 1, (1 << CFG_IDX_W) - 1)),
                {$urandom, $urandom});
    cfg_close();

    // planted copies use the configured bytes; bad lengths still plant some
    plant = (len == 0) ? 4 : ((len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : len);
    case (kind)
      PH_LONGEST: n = $urandom_range(150, 250);
      PH_BAD_LEN: n = $urandom_range(20, 40);
      default:    n = $urandom_range(40, 120);
    endcase
    k = 0;
    while (k < n) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        // one byte of a broken copy gets a random value
        bad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, plant - 1) : -1;
        for (int i = 0; i < plant; i++)
          push_byte((i == bad) ? BYTE_W'($urandom_range(0, 255)) : w[i/8][(i%8)*8 +: 8],
                    (i == 0) ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 49) == 0));
        k += plant;
      end else begin
        push_byte((r < 85) ? alpha[$urandom_range(0, alpha_n - 1)] : BYTE_W'($urandom_range(0, 255)),
                  $urandom_range(0, 29) == 0);
        k++;
      end
    end
  endtask

  phase_kind_t kind;

  initial begin
    foreach (win_bytes[i]) win_bytes[i] = '0;
    text_pos = '0;
    pat_len  = LEN_W'(1);
    foreach (pat_word[j]) pat_word[j] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset config is a one-byte pattern of zero. Text before any new_text
    // counts from index 0, so matches land at 0 and 2.
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    wait_idle();

    // Length zero (upper data bits set, all ignored): nothing may match.
    cfg_write(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFC0);
    cfg_close();
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    wait_idle();

    // Largest encodable length, above the window size: nothing may match.
    cfg_write(REG_PATTERN_LENGTH, 64'h0000_0000_0000_003F);
    cfg_close();
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    wait_idle();

    // Writes to unused indexes must not disturb anything. Then pattern "aaa":
    // overlapping occurrences, a restart inside a partial match, short text.
    cfg_write(CFG_IDX_W'(int'(REG_PATTERN_24_31) + 1), '1);
    cfg_write(CFG_IDX_W'((1 << CFG_IDX_W) - 1), '1);
    cfg_write(REG_PATTERN_0_7, 64'hFFFF_FFFF_FF61_6161);
    cfg_write(REG_PATTERN_LENGTH, 64'd3);
    cfg_close();
    push_byte(8'h61, 1'b1);
    repeat (4) push_byte(8'h61, 1'b0);
    push_byte(8'h61, 1'b1);
    push_byte(8'h61, 1'b0);
    push_byte(8'h62, 1'b0);
    push_byte(8'h61, 1'b1);
    push_byte(8'h61, 1'b0);
    wait_idle();

    // Random phases, each drained before the next config so the sender also
    // pauses until every match has come out. Longest and bad lengths recur.
    items_queued = 0;
    while (items_queued < TEXT_TARGET) begin
      phases++;
      if (phases == 1 || phases % 7 == 3) kind = PH_LONGEST;
      else if (phases % 5 == 2)           kind = PH_BAD_LEN;
      else                                kind = PH_NORMAL;
      if (kind == PH_LONGEST) longest_runs++;
      if (kind == PH_BAD_LEN) bad_len_runs++;
      random_phase(kind);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    $display("Sent %0d text bytes over %0d pattern settings (%0d full-length, %0d invalid).",
             items_sent, phases, longest_runs, bad_len_runs);
    $display("Checked %0d match starts; %0d long hold-offs, %0d input-stall cycles.",
             results_seen, holds_done, input_stalls);
    if (mismatches == 0 && start_queue.size() == 0) begin
      $display("PASS stream_pattern_match_top");
    end else begin
      $display("%0d mismatches, %0d matches missing", mismatches, start_queue.size());
      $display("FAIL stream_pattern_match_top");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(10_000_000);
    $display("Timed out with %0d matches still pending", start_queue.size());
    $display("FAIL stream_pattern_match_top");
    $finish;
  end

endmodule

// ----- sim.f -----
src/spm_pkg.sv
src/spm_cfg.sv
src/spm_compare.sv
src/stream_pattern_match_top.sv
tb/testbench.sv
